// ===== src/fmbft_pkg.sv =====
// Shared types and constants for the FM bus front end and slot timing block.
package fmbft_pkg;

  // Kind of request on the input stream
  typedef enum logic [2:0] {
    FUNC_CLK_LOW  = 3'd0,
    FUNC_CLK_HIGH = 3'd1,
    FUNC_PIN_IC   = 3'd2,
    FUNC_PIN_WR   = 3'd3,
    FUNC_PIN_RD   = 3'd4,
    FUNC_PIN_CS   = 3'd5,
    FUNC_PIN_ADDR = 3'd6,
    FUNC_PIN_DATA = 3'd7
  } func_code_t;

  localparam int unsigned DECODE_W   = 26;
  localparam int unsigned PRESCALE_W = 6;
  localparam int unsigned RCHK_W     = 5;
  localparam int unsigned BUSY_W     = 5;
  localparam int unsigned OUT_DATA_W = 48;

  // Prescaler taps that drive the two internal phase enables
  localparam logic [PRESCALE_W-1:0] PH1_TAPS = 6'h21;
  localparam logic [PRESCALE_W-1:0] PH2_TAPS = 6'h0c;

  // One result item
  typedef struct packed {
    logic                busy_res;
    logic [DECODE_W-1:0] timing_decode;
    logic                eg_clock;
    logic                op4_sel;
    logic [8:0]          latched_data;
    logic                latched_bank;
    logic                phase1_enable;
    logic                phase2_enable;
    logic                addr_write_strobe;
    logic                data_write_strobe;
  } result_t;

endpackage

// ===== src/fmbft_core.sv =====
// Latch state of the bus front end: pins, prescaler, write sync, busy timer, slot decode.
module fmbft_core #(
  parameter int unsigned RESET_DELAY_STAGES = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  fmbft_pkg::func_code_t  func,
  input  logic [7:0]             pin_value,
  input  logic                   decode_variant,
  output fmbft_pkg::result_t     result
);
  import fmbft_pkg::*;

  localparam int unsigned RH_W = RESET_DELAY_STAGES;

  // Pin levels (read pin level has no effect on any state, so it is not kept)
  logic       pin_ic, pin_wr, pin_cs;
  logic [1:0] pin_addr;
  logic [7:0] pin_data;
  logic       pin_ic_next, pin_wr_next, pin_cs_next;
  logic [1:0] pin_addr_next;
  logic [7:0] pin_data_next;

  // Master (0) and slave (1) latch pairs
  logic [RH_W-1:0]       rh0, rh1, rh0_next, rh1_next;
  logic [RCHK_W-1:0]     rc0, rc1, rc0_next, rc1_next;
  logic [PRESCALE_W-1:0] ps0, ps1, ps0_next, ps1_next;
  logic                  ph1_0, ph1_1, ph2_0, ph2_1;
  logic                  ph1_0_next, ph1_1_next, ph2_0_next, ph2_1_next;

  // Write triggers and their sync/latch/edge stages
  logic trig_a, trig_d, sync_a, sync_d, lat_a, lat_d, edge_d0, edge_d1;
  logic trig_a_next, trig_d_next, sync_a_next, sync_d_next;
  logic lat_a_next, lat_d_next, edge_d0_next, edge_d1_next;

  // Busy timer
  logic [BUSY_W-1:0] bc0, bc1, bc0_next, bc1_next;
  logic              bs0, bs1, bs0_next, bs1_next;

  // Slot counter
  logic [1:0] sl0, sl1, sl0_next, sl1_next;
  logic [3:0] sh0, sh0_next;
  logic [2:0] sh1, sh1_next;

  // Data/bank latch and decode outputs
  logic [8:0]          held_data, held_data_next;
  logic                held_bank, held_bank_next;
  logic [DECODE_W-1:0] decode_bits, decode_bits_next;
  logic                reg_eg, reg_eg_next, reg_op4, reg_op4_next;

  // Full timing decode of the 5-bit slot count
  function automatic logic [DECODE_W-1:0] full_decode(input logic [4:0] c);
    logic [DECODE_W-1:0] b;
    b[0]  = (c & 5'd30) == 5'd30;
    b[1]  = (c & 5'd28) == 5'd0;
    b[2]  = (c & 5'd30) == 5'd4;
    b[3]  = (c & 5'd30) == 5'd22;
    b[4]  = (c & 5'd28) == 5'd24;
    b[5]  = (c & 5'd30) == 5'd28;
    b[6]  = (c & 5'd30) == 5'd14;
    b[7]  = (c & 5'd28) == 5'd16;
    b[8]  = (c & 5'd30) == 5'd20;
    b[9]  = (c & 5'd30) == 5'd6;
    b[10] = (c & 5'd28) == 5'd8;
    b[11] = (c & 5'd30) == 5'd12;
    b[12] = (c & 5'd30) == 5'd30;
    b[13] = c == 5'd0;
    b[14] = c == 5'd1;
    b[15] = c == 5'd29;
    b[16] = (c & 5'd7) == 5'd1;
    b[17] = (c & 5'd28) == 5'd4;
    b[18] = c == 5'd8;
    b[19] = (c & 5'd15) == 5'd14;
    b[20] = (c & 5'd15) == 5'd4;
    b[21] = (c & 5'd15) == 5'd9;
    b[22] = c == 5'd14;
    b[23] = (c & 5'd24) == 5'd16;
    b[24] = (c & 5'd28) == 5'd24;
    b[25] = (c & 5'd30) == 5'd28;
    return b;
  endfunction

  // Next state for one request, evaluated in latch order
  always_comb begin
    logic                  cw, chk, wd_en, ovf, slot_rst;
    logic [BUSY_W:0]       cnt;
    logic [PRESCALE_W-1:0] p;
    logic [4:0]            c;

    pin_ic_next = pin_ic;   pin_wr_next = pin_wr;   pin_cs_next = pin_cs;
    pin_addr_next = pin_addr; pin_data_next = pin_data;
    rh0_next = rh0; rh1_next = rh1; rc0_next = rc0; rc1_next = rc1;
    ps0_next = ps0; ps1_next = ps1;
    ph1_0_next = ph1_0; ph1_1_next = ph1_1; ph2_0_next = ph2_0; ph2_1_next = ph2_1;
    trig_a_next = trig_a; trig_d_next = trig_d; sync_a_next = sync_a; sync_d_next = sync_d;
    lat_a_next = lat_a; lat_d_next = lat_d; edge_d0_next = edge_d0; edge_d1_next = edge_d1;
    bc0_next = bc0; bc1_next = bc1; bs0_next = bs0; bs1_next = bs1;
    sl0_next = sl0; sl1_next = sl1; sh0_next = sh0; sh1_next = sh1;
    held_data_next = held_data; held_bank_next = held_bank;
    decode_bits_next = decode_bits; reg_eg_next = reg_eg; reg_op4_next = reg_op4;
    cw = 1'b0; chk = 1'b0; wd_en = 1'b0; ovf = 1'b0; slot_rst = 1'b0;
    cnt = '0; p = ps1; c = '0;

    if (func == FUNC_CLK_LOW || func == FUNC_CLK_HIGH) begin
      // master or slave update of the reset and prescaler chain
      if (func == FUNC_CLK_LOW) begin
        chk        = !rh1[RH_W-1] && pin_ic;
        rh0_next   = {rh1[RH_W-2:0], pin_ic};
        ps0_next   = {p[PRESCALE_W-2:0], !chk && (p[PRESCALE_W-2:0] == '0)};
        rc0_next   = {rc1[RCHK_W-2:0], chk};
        ph1_0_next = |(p & PH1_TAPS);
        ph2_0_next = |(p & PH2_TAPS);
      end else begin
        rh1_next   = rh0;
        rc1_next   = rc0;
        ps1_next   = ps0;
        ph1_1_next = ph1_0;
        ph2_1_next = ph2_0;
      end

      // phase one: master stages of sync, busy timer and slot counter
      if (ph1_1_next) begin
        wd_en        = !edge_d1 && lat_d;
        cnt          = {1'b0, bc1} + {{BUSY_W{1'b0}}, bs1};
        ovf          = cnt[BUSY_W];
        sync_a_next  = trig_a;
        sync_d_next  = trig_d;
        edge_d0_next = lat_d;
        bs0_next     = wd_en || (bs1 && !(pin_ic || ovf));
        bc0_next     = pin_ic ? '0 : cnt[BUSY_W-1:0];
        slot_rst     = rc1_next[RCHK_W-1];
        sl0_next     = (slot_rst || sl1[1]) ? 2'd0 : sl1 + 2'd1;
        sh0_next     = sl1[1] ? {1'b0, sh1} + 4'd1 : {1'b0, sh1};
        if (slot_rst) begin
          sh0_next = '0;
        end
      end

      // phase two: slave stages and timing decode
      if (ph2_1_next) begin
        lat_a_next = sync_a_next;
        if (lat_a_next) begin
          trig_a_next = 1'b0;
        end
        lat_d_next = sync_d_next;
        if (lat_d_next) begin
          trig_d_next = 1'b0;
        end
        edge_d1_next = edge_d0_next;
        bc1_next     = bc0_next;
        bs1_next     = bs0_next;
        sl1_next     = sl0_next;
        sh1_next     = sh0_next[2:0];
        c            = {sh1_next, sl1_next};
        if (decode_variant) begin
          decode_bits_next = full_decode(c);
        end else begin
          reg_eg_next  = c == 5'd0;
          reg_op4_next = (c <= 5'd2) || (c >= 5'd4 && c <= 5'd6);
        end
      end
    end else begin
      // pin change; a read pin change still re-evaluates the bus latches
      case (func)
        FUNC_PIN_IC:   pin_ic_next   = pin_value[0];
        FUNC_PIN_WR:   pin_wr_next   = pin_value[0];
        FUNC_PIN_CS:   pin_cs_next   = pin_value[0];
        FUNC_PIN_ADDR: pin_addr_next = pin_value[1:0];
        FUNC_PIN_DATA: pin_data_next = pin_value;
        default: ;
      endcase
      cw = pin_cs_next && pin_wr_next;
      if (cw) begin
        held_data_next = {pin_addr_next[1], pin_data_next};
        held_bank_next = pin_addr_next[1];
      end
      if ((cw && !pin_addr_next[0]) || pin_ic_next) begin
        trig_a_next = 1'b1;
      end
      if (cw && pin_addr_next[0] && !pin_ic_next) begin
        trig_d_next = 1'b1;
      end
      if (ph1_1) begin
        sync_a_next = trig_a_next;
        sync_d_next = trig_d_next;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_ic <= 1'b0; pin_wr <= 1'b0; pin_cs <= 1'b0; pin_addr <= '0; pin_data <= '0;
      rh0 <= '0; rh1 <= '0; rc0 <= '0; rc1 <= '0; ps0 <= '0; ps1 <= '0;
      ph1_0 <= 1'b0; ph1_1 <= 1'b0; ph2_0 <= 1'b0; ph2_1 <= 1'b0;
      trig_a <= 1'b0; trig_d <= 1'b0; sync_a <= 1'b0; sync_d <= 1'b0;
      lat_a <= 1'b0; lat_d <= 1'b0; edge_d0 <= 1'b0; edge_d1 <= 1'b0;
      bc0 <= '0; bc1 <= '0; bs0 <= 1'b0; bs1 <= 1'b0;
      sl0 <= '0; sl1 <= '0; sh0 <= '0; sh1 <= '0;
      held_data <= '0; held_bank <= 1'b0;
      decode_bits <= '0; reg_eg <= 1'b0; reg_op4 <= 1'b0;
    end else if (step) begin
      pin_ic <= pin_ic_next; pin_wr <= pin_wr_next; pin_cs <= pin_cs_next;
      pin_addr <= pin_addr_next; pin_data <= pin_data_next;
      rh0 <= rh0_next; rh1 <= rh1_next; rc0 <= rc0_next; rc1 <= rc1_next;
      ps0 <= ps0_next; ps1 <= ps1_next;
      ph1_0 <= ph1_0_next; ph1_1 <= ph1_1_next; ph2_0 <= ph2_0_next; ph2_1 <= ph2_1_next;
      trig_a <= trig_a_next; trig_d <= trig_d_next;
      sync_a <= sync_a_next; sync_d <= sync_d_next;
      lat_a <= lat_a_next; lat_d <= lat_d_next;
      edge_d0 <= edge_d0_next; edge_d1 <= edge_d1_next;
      bc0 <= bc0_next; bc1 <= bc1_next; bs0 <= bs0_next; bs1 <= bs1_next;
      sl0 <= sl0_next; sl1 <= sl1_next; sh0 <= sh0_next; sh1 <= sh1_next;
      held_data <= held_data_next; held_bank <= held_bank_next;
      decode_bits <= decode_bits_next; reg_eg <= reg_eg_next; reg_op4 <= reg_op4_next;
    end
  end

  // Result as seen after this request
  always_comb begin
    result.busy_res          = bs1_next;
    result.timing_decode     = decode_bits_next;
    result.eg_clock          = reg_eg_next;
    result.op4_sel           = reg_op4_next;
    result.latched_data      = held_data_next;
    result.latched_bank      = held_bank_next;
    result.phase1_enable     = ph1_1_next;
    result.phase2_enable     = ph2_1_next;
    result.addr_write_strobe = lat_a_next;
    result.data_write_strobe = lat_d_next;
  end

endmodule

// ===== src/fm_bus_front_end_timing.sv =====
// Top level of the FM bus front end: stream handshake, result register, decode select.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------
//  s_*      | in  | s_tvalid / s_tready    | s_tuser: func, s_tdata: pin_value
//  m_*      | out | m_tvalid / m_tready    | m_tdata: result fields
//  cfg_*    | in  | cfg_valid / cfg_ready  | cfg_data: decode_variant
//
// One request per cycle while m_tready does not stall the output; each result is registered as its request is taken.
// The request is taken whenever the result register is empty or being drained,
// so the state latches and the result register advance together.
// rst is synchronous and clears all latch state and the decode select.
// A stall on m_tready holds the result and stops s_tready; cfg_ready is always high.
module fm_bus_front_end_timing #(
  parameter int unsigned RESET_DELAY_STAGES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pin_value
  input  logic [2:0]  s_tuser,   // [2:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [fmbft_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tdata: [0] busy_res, [26:1] timing_decode, [27] eg_clock, [28] op4_sel,
  //          [37:29] latched_data, [38] latched_bank, [39] phase1_enable,
  //          [40] phase2_enable, [41] addr_write_strobe, [42] data_write_strobe,
  //          [47:43] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // decode_variant
);
  import fmbft_pkg::*;

  logic    decode_variant;
  logic    accept;
  result_t result;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Decode variant register
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_variant <= 1'b0;
    end else if (cfg_valid) begin
      decode_variant <= cfg_data;
    end
  end

  fmbft_core #(
    .RESET_DELAY_STAGES(RESET_DELAY_STAGES)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .func          (func_code_t'(s_tuser)),
    .pin_value     (s_tdata),
    .decode_variant(decode_variant),
    .result        (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'd0, result.data_write_strobe, result.addr_write_strobe,
                  result.phase2_enable, result.phase1_enable, result.latched_bank,
                  result.latched_data, result.op4_sel, result.eg_clock,
                  result.timing_decode, result.busy_res};
    end
  end

endmodule
